### rtl/ffra_pkg.sv
// Shared field widths, result codes and control types of the first-fit run allocator.
package ffra_pkg;

   // Field widths of the request and response items.
   localparam int OWNER_W = 8;
   localparam int SIZE_W  = 11;
   localparam int STAT_W  = 2;
   localparam int ADDR_W  = 10;
   localparam int FREE_W  = 11;

   // Packed widths of the stream data buses, padded to whole bytes.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Width of one ownership map entry.
   localparam int ENTRY_W = 8;

   // Owner id that cannot be stored, since its encoded value would overflow an entry.
   localparam logic [OWNER_W-1:0] OWNER_INVALID = 8'hFF;

   // Response status codes.
   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NO_RUN   = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_BAD_OWNR = 2'd3;

   // Outcome of a map scan, reported by the scanner to the controller.
   typedef struct packed {
      logic done;
      logic found;
   } scan_status_type;

endpackage

### rtl/ffra_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data valid in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ffra_scan.sv
// Map scanner: streams the ownership map through the RAM read port and finds the
// lowest free run that is long enough for the request.
module ffra_scan
   import ffra_pkg::*;
#(
   parameter int MAP_ENTRIES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SIZE_W-1:0]              size,
   output logic [$clog2(MAP_ENTRIES)-1:0] rd_addr,
   input  logic [ENTRY_W-1:0]             rd_data,
   output scan_status_type                status,
   output logic [$clog2(MAP_ENTRIES)-1:0] run_start
);

   localparam int AW = $clog2(MAP_ENTRIES);
   localparam int FW = $clog2(MAP_ENTRIES + 1);
   localparam int CW = (FW > SIZE_W) ? FW : SIZE_W;
   localparam int EW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAP_ENTRIES - 1);

   logic              active_ff, active_in;
   logic              issued_all_ff, issued_all_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     pidx_ff, pidx_in;
   logic [FW-1:0]     run_ff, run_in;
   logic [SIZE_W-1:0] size_ff, size_in;

   logic              issue;
   logic              free_hit;
   logic              hit;
   logic              last;
   logic [FW-1:0]     run_new;
   logic [EW-1:0]     start_ext;

   // Compare the entry that returns this cycle and extend or break the current run.
   always_comb begin
      issue     = active_ff && !issued_all_ff;
      free_hit  = pend_ff && (rd_data == '0);
      run_new   = free_hit ? FW'(run_ff + 1'b1) : '0;
      hit       = active_ff && free_hit && (CW'(run_new) >= CW'(size_ff));
      last      = pend_ff && (pidx_ff == LAST_IDX);
      start_ext = EW'(pidx_ff) + EW'(1) - EW'(size_ff);
      rd_addr   = addr_ff;
      run_start = start_ext[AW-1:0];
      status.done  = active_ff && (hit || last);
      status.found = hit;
   end

   // Next state of the read sequencer and the run counter.
   always_comb begin
      active_in     = active_ff;
      issued_all_in = issued_all_ff;
      pend_in       = pend_ff;
      addr_in       = addr_ff;
      pidx_in       = pidx_ff;
      run_in        = run_ff;
      size_in       = size_ff;
      if (start) begin
         active_in     = 1'b1;
         issued_all_in = 1'b0;
         pend_in       = 1'b0;
         addr_in       = '0;
         run_in        = '0;
         size_in       = size;
      end else if (active_ff) begin
         if (status.done) begin
            active_in = 1'b0;
            pend_in   = 1'b0;
         end else begin
            pend_in = issue;
            pidx_in = addr_ff;
            if (issue) begin
               addr_in       = AW'(addr_ff + 1'b1);
               issued_all_in = (addr_ff == LAST_IDX);
            end
            if (pend_ff) begin
               run_in = run_new;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         issued_all_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         active_ff     <= active_in;
         issued_all_ff <= issued_all_in;
         pend_ff       <= pend_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      pidx_ff <= pidx_in;
      run_ff  <= run_in;
      size_ff <= size_in;
   end

endmodule

### rtl/first_fit_run_allocator_unit.sv
// First-fit run allocator: top level with request control, map writer and response register.
// Refused and zero-size requests go straight to the response stage after acceptance; an
// allocation first scans the map and then writes the owner into each unit of the run.
// One request at a time: a new request is taken only once the last response is registered.
// The ownership map RAM has a single read port and a single write port.
// Reset: synchronous; the map is cleared by a pass over all MAP_ENTRIES entries with req_tready low,
// and the free count returns to MAP_ENTRIES.
module first_fit_run_allocator_unit
   import ffra_pkg::*;
#(
   parameter int MAP_ENTRIES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // owner_id[7:0], request_size[18:8], zeros
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[1:0], start_address[11:2],
                                             // free_units[22:12], zeros
);

   localparam int AW = $clog2(MAP_ENTRIES);
   localparam int FW = $clog2(MAP_ENTRIES + 1);
   localparam int CW = (FW > SIZE_W) ? FW : SIZE_W;
   localparam int SW = (AW > ADDR_W) ? AW : ADDR_W;
   localparam int VW = (FW > FREE_W) ? FW : FREE_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAP_ENTRIES - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [FW-1:0]      free_ff, free_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic [FW-1:0]      cnt_ff, cnt_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [AW-1:0]      res_start_ff, res_start_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [FREE_W-1:0]  rsp_free_ff, rsp_free_in;

   logic [OWNER_W-1:0] req_owner;
   logic [SIZE_W-1:0]  req_size;
   logic               req_accept;
   logic               scan_start;
   scan_status_type    scan_st;
   logic [AW-1:0]      scan_run_start;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               rsp_load;
   logic [SW-1:0]      start_ext;
   logic [VW-1:0]      free_ext;

   // Request fields.
   assign req_owner  = req_tdata[OWNER_W-1:0];
   assign req_size   = req_tdata[OWNER_W+SIZE_W-1:OWNER_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Ownership map; the controller never scans and writes at once, so no forwarding is needed.
   ffra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAP_ENTRIES)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ffra_scan #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .size      (req_size),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .status    (scan_st),
      .run_start (scan_run_start)
   );

   // Map write port: zeros during the clearing pass, the encoded owner during allocation.
   always_comb begin
      mem_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      mem_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : wr_addr_ff;
      mem_wr_data = (state_ff == ST_CLEAR) ? '0 : ENTRY_W'(owner_ff + 1'b1);
   end

   // Response register loads from the pending result once the output slot is free.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      start_ext = SW'(res_start_ff);
      free_ext  = VW'(free_ff);
   end

   // Request sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      free_in       = free_ff;
      owner_in      = owner_ff;
      size_in       = size_ff;
      wr_addr_in    = wr_addr_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      scan_start    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = AW'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               owner_in     = req_owner;
               size_in      = req_size;
               res_start_in = '0;
               if (req_owner == OWNER_INVALID) begin
                  res_status_in = STATUS_BAD_OWNR;
                  state_in      = ST_DONE;
               end else if (req_size == '0) begin
                  res_status_in = STATUS_OK;
                  state_in      = ST_DONE;
               end else if (CW'(req_size) > CW'(free_ff)) begin
                  res_status_in = STATUS_NO_FREE;
                  state_in      = ST_DONE;
               end else begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_st.done) begin
               if (scan_st.found) begin
                  wr_addr_in   = scan_run_start;
                  res_start_in = scan_run_start;
                  cnt_in       = FW'(size_ff);
                  state_in     = ST_WRITE;
               end else begin
                  res_status_in = STATUS_NO_RUN;
                  res_start_in  = '0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_WRITE: begin
            wr_addr_in = AW'(wr_addr_ff + 1'b1);
            cnt_in     = FW'(cnt_ff - 1'b1);
            if (cnt_ff == FW'(1)) begin
               free_in       = FW'(free_ff - FW'(size_ff));
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;
      rsp_start_in  = rsp_load ? start_ext[ADDR_W-1:0] : rsp_start_ff;
      rsp_free_in   = rsp_load ? free_ext[FREE_W-1:0] : rsp_free_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         free_ff      <= FW'(MAP_ENTRIES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      owner_ff      <= owner_in;
      size_ff       <= size_in;
      wr_addr_ff    <= wr_addr_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Response port.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - STAT_W - ADDR_W - FREE_W){1'b0}},
                        rsp_free_ff, rsp_start_ff, rsp_status_ff};

   // The free count never exceeds the map size.
   assert property (@(posedge clock) disable iff (reset)
      CW'(free_ff) <= CW'(MAP_ENTRIES))
      else $error("free count above map size");

   // The last owner write takes exactly the request size off the free count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && cnt_ff == FW'(1)) |=>
         free_ff == FW'($past(free_ff) - FW'($past(size_ff))))
      else $error("free count not reduced by request size");

   // A found run lies wholly inside the map.
   assert property (@(posedge clock) disable iff (reset)
      (scan_st.done && scan_st.found) |->
         (32'(scan_run_start) + 32'(size_ff)) <= 32'(MAP_ENTRIES))
      else $error("found run extends past the map");

   // The scanner reports only while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      scan_st.done |-> state_ff == ST_SCAN)
      else $error("scan result outside the scan phase");

endmodule
